// ----- src/dpt_pkg.sv -----
// Package with shared constants, codes and types for the divider and programmable timer.
package dpt_pkg;

	localparam int DIV_W = 16;
	localparam int ACC_W = 16;
	localparam int CNT_W = 8;
	localparam int PERIOD_W = 11;
	localparam int RATE_W = 2;
	localparam int ADDR_W = 4;
	localparam int DATA_W = 32;

	localparam logic [DIV_W-1:0] DIVIDER_RESET = 16'hABCC;

	typedef enum logic [1:0] {
		REG_ENABLE = 2'd0,
		REG_RATE   = 2'd1,
		REG_RELOAD = 2'd2
	} reg_index_t;

	typedef enum logic {
		KIND_TICK  = 1'b0,
		KIND_WRITE = 1'b1
	} item_kind_t;

	typedef struct packed {
		logic             timer_interrupt;
		logic [CNT_W-1:0] counter_value;
		logic [CNT_W-1:0] divider_byte;
	} result_t;

	function automatic logic [PERIOD_W-1:0] period_of(input logic [RATE_W-1:0] rate);
		logic [PERIOD_W-1:0] p;
		case (rate)
			2'd0: p = 11'd1024;
			2'd1: p = 11'd16;
			2'd2: p = 11'd64;
			2'd3: p = 11'd256;
			default: p = 11'd1024;
		endcase
		return p;
	endfunction

endpackage

// ----- src/divider_and_programmable_timer_unit.sv -----
// Top level of the divider and programmable timer with stream channels and a register port.
//
// Usage: each transaction on the s_ channel is either a tick (s_tuser low), which adds
// s_tdata[7:0] elapsed cycles to the 16-bit divider and, while enabled, to the cycle
// accumulator, or a counter write (s_tuser high), which loads s_tdata[15:8] into the
// 8-bit counter. Every input transaction produces exactly one output transaction on the
// m_ channel carrying the divider upper byte, the counter value and the overflow flag.
// The three registers (enable, rate select, reload value) are at byte addresses 0, 4 and 8
// of the APB port; the user must write them only while the block is idle (the block itself
// leaves this unchecked); reads return their values. Results are registered. The state
// update is a single add, compare and subtract done in the cycle of acceptance, so one
// transaction is accepted every cycle while s_tready is high. The output register is
// backed by a one-entry skid register, so the input keeps flowing for one more transaction
// while the receiver stalls; after that s_tready falls until the receiver takes a result.
// Reset clears the registers, the accumulator and the counter, sets the divider to
// 0xABCC and empties the output stage.
module divider_and_programmable_timer_unit (
	input  logic                        clk,
	input  logic                        arst_n,
	input  logic                        s_tvalid,
	output logic                        s_tready,
	input  logic [15:0]                 s_tdata,  // cycles [7:0], write_data [15:8]
	input  logic                        s_tuser,  // kind [0]
	output logic                        m_tvalid,
	input  logic                        m_tready,
	output logic [15:0]                 m_tdata,  // divider_byte [7:0], counter_value [15:8]
	output logic                        m_tuser,  // timer_interrupt [0]
	input  logic                        psel,
	input  logic                        penable,
	input  logic                        pwrite,
	input  logic [dpt_pkg::ADDR_W-1:0]  paddr,
	input  logic [dpt_pkg::DATA_W-1:0]  pwdata,
	output logic [dpt_pkg::DATA_W-1:0]  prdata,
	output logic                        pready
);
	import dpt_pkg::*;

	logic                enable_q;
	logic [RATE_W-1:0]   rate_q;
	logic [CNT_W-1:0]    reload_q;
	logic [DIV_W-1:0]    divider_q;
	logic [ACC_W-1:0]    acc_q;
	logic [CNT_W-1:0]    count_q;
	result_t             out_q;
	result_t             skid_q;
	logic                out_valid_q;
	logic                skid_valid_q;

	logic                cfg_write;
	logic [1:0]          cfg_index;
	logic                accept;
	logic                pop;
	logic [CNT_W-1:0]    cycles;
	logic [CNT_W-1:0]    write_data;
	logic [DIV_W-1:0]    divider_next;
	logic [ACC_W-1:0]    acc_sum;
	logic [ACC_W-1:0]    acc_next;
	logic [CNT_W-1:0]    count_next;
	logic [PERIOD_W-1:0] period;
	logic                reached;
	logic                irq;
	result_t             result;

	assign pready = 1'b1;
	assign cfg_write = psel & penable & pwrite;
	assign cfg_index = paddr[3:2];

	always_comb begin
		prdata = '0;
		case (cfg_index)
			REG_ENABLE: prdata = {{(DATA_W-1){1'b0}}, enable_q};
			REG_RATE:   prdata = {{(DATA_W-RATE_W){1'b0}}, rate_q};
			REG_RELOAD: prdata = {{(DATA_W-CNT_W){1'b0}}, reload_q};
			default:    prdata = '0;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			enable_q <= 1'b0;
			rate_q   <= '0;
			reload_q <= '0;
		end else if (cfg_write) begin
			case (cfg_index)
				REG_ENABLE: enable_q <= pwdata[0];
				REG_RATE:   rate_q   <= pwdata[RATE_W-1:0];
				REG_RELOAD: reload_q <= pwdata[CNT_W-1:0];
				default:    ;
			endcase
		end
	end

	assign s_tready = ~skid_valid_q;
	assign accept = s_tvalid & s_tready;
	assign pop = out_valid_q & m_tready;
	assign cycles = s_tdata[7:0];
	assign write_data = s_tdata[15:8];

	assign period = period_of(rate_q);
	assign acc_sum = acc_q + {{(ACC_W-CNT_W){1'b0}}, cycles};
	assign reached = acc_sum >= {{(ACC_W-PERIOD_W){1'b0}}, period};

	always_comb begin
		divider_next = divider_q;
		acc_next = acc_q;
		count_next = count_q;
		irq = 1'b0;
		if (s_tuser == KIND_WRITE) begin
			count_next = write_data;
		end else begin
			divider_next = divider_q + {{(DIV_W-CNT_W){1'b0}}, cycles};
			if (enable_q) begin
				acc_next = acc_sum;
				if (reached) begin
					acc_next = acc_sum - {{(ACC_W-PERIOD_W){1'b0}}, period};
					if (count_q == {CNT_W{1'b1}}) begin
						count_next = reload_q;
						irq = 1'b1;
					end else begin
						count_next = count_q + {{(CNT_W-1){1'b0}}, 1'b1};
					end
				end
			end
		end
		result.divider_byte = divider_next[DIV_W-1 -: CNT_W];
		result.counter_value = count_next;
		result.timer_interrupt = irq;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			divider_q <= DIVIDER_RESET;
			acc_q     <= '0;
			count_q   <= '0;
		end else if (accept) begin
			divider_q <= divider_next;
			acc_q     <= acc_next;
			count_q   <= count_next;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q  <= 1'b0;
			skid_valid_q <= 1'b0;
		end else if (skid_valid_q) begin
			if (pop) begin
				skid_valid_q <= 1'b0;
			end
		end else if (accept) begin
			if (!out_valid_q || pop) begin
				out_valid_q <= 1'b1;
			end else begin
				skid_valid_q <= 1'b1;
			end
		end else if (pop) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (skid_valid_q) begin
			if (pop) begin
				out_q <= skid_q;
			end
		end else if (accept) begin
			if (!out_valid_q || pop) begin
				out_q <= result;
			end else begin
				skid_q <= result;
			end
		end
	end

	assign m_tvalid = out_valid_q;
	assign m_tdata = {out_q.counter_value, out_q.divider_byte};
	assign m_tuser = out_q.timer_interrupt;

	a_skid_implies_out: assert property (@(posedge clk) disable iff (!arst_n)
		skid_valid_q |-> out_valid_q)
		else $error("Skid register holds a result while the output register is empty.");

	a_write_loads_counter: assert property (@(posedge clk) disable iff (!arst_n)
		(accept && s_tuser == KIND_WRITE) |=> count_q == $past(write_data))
		else $error("Counter write did not load the counter.");

	a_tick_advances_divider: assert property (@(posedge clk) disable iff (!arst_n)
		(accept && s_tuser == KIND_TICK)
		|=> divider_q == $past(divider_q + {{(DIV_W-CNT_W){1'b0}}, cycles}))
		else $error("Divider did not advance by the tick cycle count.");

	a_disabled_acc_holds: assert property (@(posedge clk) disable iff (!arst_n)
		!enable_q |=> acc_q == $past(acc_q))
		else $error("Cycle accumulator changed while the timer was disabled.");

endmodule

// ----- test/testbench.sv -----
`timescale 1ns / 1ps
// Self-checking stream and register-port testbench for the divider and programmable timer unit.
module testbench;
	import dpt_pkg::*;

	typedef struct packed {
		item_kind_t kind;
		logic [7:0] cycles;
		logic [7:0] write_data;
	} timer_item_t;

	localparam logic [ADDR_W-1:0] UNMAPPED_ADDR = 4'd12;
	localparam int PERIOD_BY_RATE [4] = '{1024, 16, 64, 256};

	logic                clk = 1'b0;
	logic                arst_n = 1'b0;
	logic                s_tvalid = 1'b0;
	logic                s_tready;
	logic [15:0]         s_tdata = '0;  // cycles [7:0], write_data [15:8]
	logic                s_tuser = 1'b0;  // kind [0]
	logic                m_tvalid;
	logic                m_tready = 1'b0;
	logic [15:0]         m_tdata;  // divider_byte [7:0], counter_value [15:8]
	logic                m_tuser;  // timer_interrupt [0]
	logic                psel = 1'b0;
	logic                penable = 1'b0;
	logic                pwrite = 1'b0;
	logic [ADDR_W-1:0]   paddr = '0;
	logic [DATA_W-1:0]   pwdata = '0;
	logic [DATA_W-1:0]   prdata;
	logic                pready;

	divider_and_programmable_timer_unit dut (
		.clk(clk), .arst_n(arst_n),
		.s_tvalid(s_tvalid), .s_tready(s_tready), .s_tdata(s_tdata), .s_tuser(s_tuser),
		.m_tvalid(m_tvalid), .m_tready(m_tready), .m_tdata(m_tdata), .m_tuser(m_tuser),
		.psel(psel), .penable(penable), .pwrite(pwrite), .paddr(paddr),
		.pwdata(pwdata), .prdata(prdata), .pready(pready)
	);

	// Shadow copy of the timer registers and state.
	logic        enable_model = 1'b0;
	logic [1:0]  rate_model = '0;
	logic [7:0]  reload_model = '0;
	logic [15:0] divider_model = DIVIDER_RESET;
	logic [15:0] accum_model = '0;
	logic [7:0]  count_model = '0;

	timer_item_t items_queued[$];
	result_t     results_due[$];
	timer_item_t in_flight;
	int          send_gap = 0;
	int          hold_gap = 0;
	bit          calm = 1'b0;
	int          errors = 0;
	int          items_sent = 0;
	int          counter_writes = 0;
	int          results_checked = 0;
	int          overflows_seen = 0;
	int          settings_used = 0;

	always begin
		#5 clk = 1'b1;
		#5 clk = 1'b0;
	end

	function automatic result_t advance_timer(input timer_item_t it);
		result_t r;
		logic    irq;
		irq = 1'b0;
		if (it.kind == KIND_WRITE) begin
			count_model = it.write_data;
		end else begin
			divider_model = divider_model + 16'(it.cycles);
			if (enable_model) begin
				accum_model = accum_model + 16'(it.cycles);
				if (int'(accum_model) >= PERIOD_BY_RATE[rate_model]) begin
					if (count_model == 8'hFF) begin
						count_model = reload_model;
						irq = 1'b1;
					end else begin
						count_model = count_model + 8'd1;
					end
					accum_model = accum_model - 16'(PERIOD_BY_RATE[rate_model]);
				end
			end
		end
		r.divider_byte = divider_model[15:8];
		r.counter_value = count_model;
		r.timer_interrupt = irq;
		return r;
	endfunction

	function automatic void compare_field(input string name, input int want, input int got);
		if (want != got) begin
			$display("%0t: %s mismatch, expected %0d, actual %0d", $time, name, want, got);
			errors++;
		end
	endfunction

	always @(posedge clk) begin : driver
		timer_item_t nxt;
		logic        busy;
		if (!arst_n) begin
			s_tvalid <= 1'b0;
			send_gap <= 0;
		end else begin
			busy = s_tvalid;
			if (s_tvalid && s_tready) begin
				results_due.push_back(advance_timer(in_flight));
				items_sent++;
				busy = 1'b0;
			end
			if (!busy) begin
				if (send_gap > 0) begin
					send_gap <= send_gap - 1;
					s_tvalid <= 1'b0;
				end else if (items_queued.size() != 0) begin
					nxt = items_queued.pop_front();
					in_flight <= nxt;
					s_tvalid <= 1'b1;
					s_tdata <= {nxt.write_data, nxt.cycles};
					s_tuser <= nxt.kind;
					if (!calm && $urandom_range(0, 5) == 0)
						send_gap <= $urandom_range(1, 10);
				end else begin
					s_tvalid <= 1'b0;
				end
			end
		end
	end

	always @(posedge clk) begin : monitor
		result_t want;
		if (!arst_n) begin
			m_tready <= 1'b0;
			hold_gap <= 0;
		end else begin
			if (m_tvalid && m_tready) begin
				if (results_due.size() == 0) begin
					$display("%0t: unexpected result, expected none, actual tdata=%h tuser=%b",
						$time, m_tdata, m_tuser);
					errors++;
				end else begin
					want = results_due.pop_front();
					results_checked++;
					if (m_tuser)
						overflows_seen++;
					compare_field("divider_byte", int'(want.divider_byte),
						int'(m_tdata[7:0]));
					compare_field("counter_value", int'(want.counter_value),
						int'(m_tdata[15:8]));
					compare_field("timer_interrupt", int'(want.timer_interrupt),
						int'(m_tuser));
				end
			end
			if (hold_gap > 0) begin
				hold_gap <= hold_gap - 1;
				m_tready <= 1'b0;
			end else begin
				m_tready <= 1'b1;
				if (!calm && $urandom_range(0, 5) == 0)
					hold_gap <= $urandom_range(1, 10);
			end
		end
	end

	task automatic write_register(input logic [ADDR_W-1:0] addr, input logic [31:0] value);
		@(posedge clk);
		psel <= 1'b1;
		penable <= 1'b0;
		pwrite <= 1'b1;
		paddr <= addr;
		pwdata <= value;
		@(posedge clk);
		penable <= 1'b1;
		@(posedge clk);
		psel <= 1'b0;
		penable <= 1'b0;
		pwrite <= 1'b0;
	endtask

	task automatic read_register(input logic [ADDR_W-1:0] addr, output logic [31:0] value);
		@(posedge clk);
		psel <= 1'b1;
		penable <= 1'b0;
		pwrite <= 1'b0;
		paddr <= addr;
		@(posedge clk);
		penable <= 1'b1;
		@(posedge clk);
		value = prdata;
		psel <= 1'b0;
		penable <= 1'b0;
	endtask

	// Upper data bits are filled with noise, since the register keeps only its own width.
	task automatic set_register(input reg_index_t idx, input logic [7:0] value);
		logic [31:0] mask;
		logic [31:0] got;
		logic [ADDR_W-1:0] addr;
		mask = (idx == REG_ENABLE) ? 32'h1 : (idx == REG_RATE) ? 32'h3 : 32'hFF;
		addr = ADDR_W'(4 * idx);
		write_register(addr, ($urandom & ~mask) | (32'(value) & mask));
		case (idx)
			REG_ENABLE: enable_model = value[0];
			REG_RATE:   rate_model = value[1:0];
			default:    reload_model = value;
		endcase
		read_register(addr, got);
		if (got !== (32'(value) & mask)) begin
			$display("%0t: register %s readback mismatch, expected %h, actual %h",
				$time, idx.name(), 32'(value) & mask, got);
			errors++;
		end
	endtask

	task automatic configure(input logic enable, input logic [1:0] rate, input logic [7:0] reload);
		set_register(REG_ENABLE, {7'(0), enable});
		set_register(REG_RATE, {6'(0), rate});
		set_register(REG_RELOAD, reload);
		settings_used++;
	endtask

	task automatic wait_idle();
		do
			@(posedge clk);
		while (items_queued.size() != 0 || s_tvalid || results_due.size() != 0);
		repeat (3) @(posedge clk);
	endtask

	function automatic void queue_tick(input logic [7:0] cycles);
		timer_item_t it;
		it.kind = KIND_TICK;
		it.cycles = cycles;
		it.write_data = 8'($urandom);
		items_queued.push_back(it);
	endfunction

	function automatic void queue_counter_write(input logic [7:0] data);
		timer_item_t it;
		it.kind = KIND_WRITE;
		it.cycles = 8'($urandom);
		it.write_data = data;
		items_queued.push_back(it);
		counter_writes++;
	endfunction

	// Counter writes often land near the top so that overflows come quickly.
	function automatic void queue_random(input int count, input int write_odds);
		for (int i = 0; i < count; i++) begin
			if ($urandom_range(0, write_odds) == 0)
				queue_counter_write(8'($urandom_range(0, 1) ?
					$urandom_range(240, 255) : $urandom));
			else
				queue_tick(8'($urandom_range(0, 2) == 0 ? $urandom_range(0, 31) : $urandom));
		end
	endfunction

	initial begin
		repeat (6) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// The timer is disabled after reset, so ticks move only the divider.
		queue_tick(8'd0);
		queue_tick(8'd255);
		queue_counter_write(8'hFF);
		queue_counter_write(8'h00);
		queue_tick(8'd52);
		wait_idle();

		configure(1'b1, 2'd1, 8'hFF);
		write_register(UNMAPPED_ADDR, $urandom);
		queue_counter_write(8'hFE);
		queue_tick(8'd16);
		queue_tick(8'd16);
		queue_tick(8'd15);
		queue_tick(8'd1);
		queue_tick(8'd255);
		queue_tick(8'd0);
		queue_tick(8'd0);
		wait_idle();

		configure(1'b0, 2'd1, 8'h00);
		queue_tick(8'd255);
		queue_tick(8'd200);
		wait_idle();

		configure(1'b1, 2'd0, 8'h00);
		queue_counter_write(8'hFF);
		queue_tick(8'd255);
		queue_tick(8'd255);
		queue_tick(8'd255);
		queue_tick(8'd255);
		wait_idle();

		configure(1'b1, 2'd3, 8'h5A);
		queue_counter_write(8'hFF);
		queue_tick(8'd255);
		queue_tick(8'd1);
		wait_idle();

		configure(1'b1, 2'd2, 8'h01);
		queue_counter_write(8'hFF);
		queue_tick(8'd64);
		wait_idle();

		configure(1'b1, 2'd1, 8'hFF);
		queue_random(70, 6);
		wait_idle();
		configure(1'b1, 2'd2, 8'h00);
		queue_random(70, 6);
		wait_idle();
		configure(1'b1, 2'd3, 8'($urandom));
		queue_random(70, 6);
		wait_idle();
		configure(1'b1, 2'd0, 8'($urandom));
		queue_random(70, 6);
		wait_idle();
		configure(1'b0, 2'($urandom), 8'($urandom));
		queue_random(60, 6);
		wait_idle();
		configure(1'b1, 2'($urandom), 8'($urandom));
		queue_random(70, 6);
		wait_idle();

		// Long run of large ticks at the shortest period so that the accumulator wraps.
		configure(1'b1, 2'd1, 8'($urandom));
		for (int i = 0; i < 330; i++) begin
			if ($urandom_range(0, 19) == 0)
				queue_counter_write(8'($urandom));
			else
				queue_tick(8'($urandom_range(192, 255)));
		end
		wait_idle();

		calm = 1'b1;
		configure(1'b1, 2'd1, 8'($urandom));
		queue_random(60, 4);
		wait_idle();
		repeat (5) @(posedge clk);

		$display("Sent %0d transactions (%0d counter writes) under %0d register settings.",
			items_sent, counter_writes, settings_used);
		$display("Checked %0d results, %0d of them with an overflow and reload.",
			results_checked, overflows_seen);
		if (errors == 0)
			$display("CHECK OK");
		else
			$display("CHECK FAILED");
		$finish;
	end

	initial begin
		#2ms;
		$display("Timeout with %0d results still outstanding.", results_due.size());
		$display("CHECK FAILED");
		$finish;
	end

endmodule
